[hw/rtl/tlca_pkg.sv]
// shared types, constants and controller command codes for the lca engine
package tlca_pkg;

    localparam int NODE_W          = 17;
    localparam int CFG_W           = 18;
    localparam int DEF_MAX_NODES   = 131072;
    localparam int DEF_LOG_LEVELS  = 17;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_DECODE,
        OP_CLR,
        OP_BINIT,
        OP_EN0,
        OP_EN1,
        OP_ENL,
        OP_ENW,
        OP_WRD,
        OP_WCHK,
        OP_WPOP,
        OP_WPOP2,
        OP_WSIB,
        OP_ERDB,
        OP_ECHK,
        OP_ERDA,
        OP_EWR,
        OP_Q0,
        OP_Q1,
        OP_Q2,
        OP_Q3,
        OP_QLA,
        OP_QLB,
        OP_QLC,
        OP_QF,
        OP_QF2,
        OP_LOAD
    } t_op;

    typedef struct packed {
        t_op  op;
        logic clr_link;
    } t_dp_ctl;

    typedef struct packed {
        logic [1:0] cmd;
        logic       bad;
        logic       link_hp;
        logic       clr_last;
        logic       lvl_last;
        logic       lvl_zero;
        logic       rd_cok;
        logic       rd_vis;
        logic       sp_one;
        logic       anc_ab;
        logic       anc_ba;
    } t_dp_sts;

endpackage

[hw/rtl/tlca_ram.sv]
// generic single write port ram with registered read
module tlca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/tlca_ctrl.sv]
// sequencing state machine for add edge, build walk and query
module tlca_ctrl
    import tlca_pkg::*;
#(
    parameter int LOG_LEVELS = DEF_LOG_LEVELS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_ctl o_ctl,
    input  t_dp_sts i_sts
);

    typedef enum logic [4:0] {
        S_RCLR, S_IDLE, S_DEC, S_BCLR, S_BINIT, S_EN0, S_EN1, S_ENL, S_ENW,
        S_WRD, S_WCHK, S_WPOP, S_WPOP2, S_WSIB, S_ERDB, S_ECHK, S_ERDA, S_EWR,
        S_Q0, S_Q1, S_Q2, S_Q3, S_QLA, S_QLB, S_QLC, S_QF, S_QF2, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    assign accept     = (r_state == S_IDLE) && i_in_valid;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_ctl.clr_link = (r_state == S_RCLR);
        unique case (r_state)
            S_RCLR, S_BCLR: o_ctl.op = OP_CLR;
            S_IDLE:  o_ctl.op = accept ? OP_LATCH : OP_NONE;
            S_DEC:   o_ctl.op = OP_DECODE;
            S_BINIT: o_ctl.op = OP_BINIT;
            S_EN0:   o_ctl.op = OP_EN0;
            S_EN1:   o_ctl.op = OP_EN1;
            S_ENL:   o_ctl.op = OP_ENL;
            S_ENW:   o_ctl.op = OP_ENW;
            S_WRD:   o_ctl.op = OP_WRD;
            S_WCHK:  o_ctl.op = OP_WCHK;
            S_WPOP:  o_ctl.op = OP_WPOP;
            S_WPOP2: o_ctl.op = OP_WPOP2;
            S_WSIB:  o_ctl.op = OP_WSIB;
            S_ERDB:  o_ctl.op = OP_ERDB;
            S_ECHK:  o_ctl.op = OP_ECHK;
            S_ERDA:  o_ctl.op = OP_ERDA;
            S_EWR:   o_ctl.op = OP_EWR;
            S_Q0:    o_ctl.op = OP_Q0;
            S_Q1:    o_ctl.op = OP_Q1;
            S_Q2:    o_ctl.op = OP_Q2;
            S_Q3:    o_ctl.op = OP_Q3;
            S_QLA:   o_ctl.op = OP_QLA;
            S_QLB:   o_ctl.op = OP_QLB;
            S_QLC:   o_ctl.op = OP_QLC;
            S_QF:    o_ctl.op = OP_QF;
            S_QF2:   o_ctl.op = OP_QF2;
            S_FIN:   o_ctl.op = out_free ? OP_LOAD : OP_NONE;
            default: o_ctl.op = OP_NONE;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RCLR:  if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = S_DEC;
            S_DEC: begin
                if (i_sts.cmd == CMD_BUILD) begin
                    n_state = S_BCLR;
                end else if (i_sts.cmd == CMD_ADD && !i_sts.bad) begin
                    n_state = S_ERDB;
                end else if (i_sts.cmd == CMD_QUERY && !i_sts.bad) begin
                    n_state = S_Q0;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_BCLR:  if (i_sts.clr_last) n_state = S_BINIT;
            S_BINIT: n_state = S_EN0;
            S_EN0:   n_state = S_EN1;
            S_EN1:   n_state = (LOG_LEVELS > 1) ? S_ENL : S_ENW;
            S_ENL:   if (i_sts.lvl_last) n_state = S_ENW;
            S_ENW:   n_state = S_WRD;
            S_WRD:   n_state = S_WCHK;
            S_WCHK: begin
                if (i_sts.rd_cok) begin
                    n_state = S_WSIB;
                end else if (i_sts.sp_one) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_WPOP;
                end
            end
            S_WPOP:  n_state = S_WPOP2;
            S_WPOP2: n_state = S_WRD;
            S_WSIB:  n_state = i_sts.rd_vis ? S_WRD : S_EN0;
            S_ERDB:  n_state = S_ECHK;
            S_ECHK:  n_state = i_sts.link_hp ? S_FIN : S_ERDA;
            S_ERDA:  n_state = S_EWR;
            S_EWR:   n_state = S_FIN;
            S_Q0:    n_state = S_Q1;
            S_Q1:    n_state = S_Q2;
            S_Q2:    n_state = S_Q3;
            S_Q3:    n_state = (i_sts.anc_ab || i_sts.anc_ba) ? S_FIN : S_QLA;
            S_QLA:   n_state = S_QLB;
            S_QLB:   n_state = S_QLC;
            S_QLC:   n_state = i_sts.lvl_zero ? S_QF : S_QLA;
            S_QF:    n_state = S_QF2;
            S_QF2:   n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RCLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[hw/rtl/tlca_dp.sv]
// datapath: tree memories, walk registers, lifting and ancestor tests
module tlca_dp
    import tlca_pkg::*;
#(
    parameter int MAX_NODES  = DEF_MAX_NODES,
    parameter int LOG_LEVELS = DEF_LOG_LEVELS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_ctl           i_ctl,
    output t_dp_sts           o_sts,
    input  logic [1:0]        i_cmd,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data,
    output logic [NODE_W-1:0] o_answer,
    output logic              o_status
);

    localparam int AW  = $clog2(MAX_NODES);
    localparam int TW  = AW + 1;
    localparam int LVW = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;

    typedef struct packed {
        logic          hp;
        logic          ok;
        logic [AW-1:0] child;
    } t_link;

    typedef struct packed {
        logic          ok;
        logic [AW-1:0] nxt;
    } t_sib;

    typedef struct packed {
        logic [TW-1:0] ent;
        logic [TW-1:0] ext;
        logic          vis;
        logic          cok;
        logic [AW-1:0] cur;
    } t_node;

    typedef logic [LOG_LEVELS-1:0][AW-1:0] t_row;

    // memory ports
    logic          link_we, sib_we, node_we, anc_we, stk_we;
    logic [AW-1:0] link_wa, sib_wa, node_wa, anc_wa, stk_wa;
    logic [AW-1:0] link_ra, sib_ra, node_ra, anc_ra, stk_ra;
    t_link         link_wd, link_rd;
    t_sib          sib_wd, sib_rd;
    t_node         node_wd, node_rd;
    t_row          anc_wd, anc_rd;
    logic [AW-1:0] stk_wd, stk_rd;

    // registers
    logic [1:0]        r_cmd;
    logic [NODE_W-1:0] r_a, r_b;
    logic [CFG_W-1:0]  r_nc;
    logic [AW-1:0]     r_ans;
    logic              r_stat;
    logic [NODE_W-1:0] r_out_ans;
    logic              r_out_stat;
    logic [AW-1:0]     r_clr;
    logic [TW-1:0]     r_timer;
    logic [AW:0]       r_sp;
    logic [AW-1:0]     r_v, r_p, r_n, r_x, r_up;
    logic [LVW-1:0]    r_lvl;
    t_row              r_row;
    t_link             r_first;
    t_node             r_nrow;
    logic [TW-1:0]     r_ea, r_xa, r_eb, r_xb;

    logic [AW-1:0]  a_addr, b_addr;
    logic [LVW-1:0] lvl_m1;
    logic [AW:0]    sp_m1;
    logic [31:0]    lim;
    logic           bad, clr_last, up_anc;

    assign a_addr = AW'(r_a);
    assign b_addr = AW'(r_b);
    assign lvl_m1 = r_lvl - LVW'(1);
    assign sp_m1  = r_sp - (AW+1)'(1);

    // effective node count: zero acts as one, clamp at capacity
    always_comb begin
        if (r_nc == '0) begin
            lim = 32'd1;
        end else if (32'(r_nc) > 32'(MAX_NODES)) begin
            lim = 32'(MAX_NODES);
        end else begin
            lim = 32'(r_nc);
        end
    end

    assign bad      = (32'(r_a) >= lim) || (32'(r_b) >= lim);
    assign clr_last = (r_clr == AW'(MAX_NODES - 1));
    assign up_anc   = (node_rd.ent <= r_eb) && (node_rd.ext >= r_xb);

    assign o_sts.cmd      = r_cmd;
    assign o_sts.bad      = bad;
    assign o_sts.link_hp  = link_rd.hp;
    assign o_sts.clr_last = clr_last;
    assign o_sts.lvl_last = (r_lvl == LVW'(LOG_LEVELS - 1));
    assign o_sts.lvl_zero = (r_lvl == '0);
    assign o_sts.rd_cok   = node_rd.cok;
    assign o_sts.rd_vis   = node_rd.vis;
    assign o_sts.sp_one   = (r_sp == (AW+1)'(1));
    assign o_sts.anc_ab   = (r_ea <= r_eb) && (r_xa >= r_xb);
    assign o_sts.anc_ba   = (r_eb <= r_ea) && (r_xb >= r_xa);

    assign o_answer = r_out_ans;
    assign o_status = r_out_stat;

    always_comb begin
        link_we = 1'b0; link_wa = '0; link_wd = '0; link_ra = '0;
        sib_we  = 1'b0; sib_wa  = '0; sib_wd  = '0; sib_ra  = '0;
        node_we = 1'b0; node_wa = '0; node_wd = '0; node_ra = '0;
        anc_we  = 1'b0; anc_wa  = '0; anc_wd  = '0; anc_ra  = '0;
        stk_we  = 1'b0; stk_wa  = '0; stk_wd  = '0; stk_ra  = '0;
        case (i_ctl.op)
            OP_CLR: begin
                node_we = 1'b1;
                node_wa = r_clr;
                anc_we  = 1'b1;
                anc_wa  = r_clr;
                link_we = i_ctl.clr_link;
                link_wa = r_clr;
            end
            OP_EN0: link_ra = r_v;
            OP_EN1: anc_ra = r_row[0];
            OP_ENL: anc_ra = anc_rd[lvl_m1];
            OP_ENW: begin
                anc_we      = 1'b1;
                anc_wa      = r_v;
                anc_wd      = r_row;
                node_we     = 1'b1;
                node_wa     = r_v;
                node_wd.ent = r_timer;
                node_wd.vis = 1'b1;
                node_wd.cok = r_first.ok;
                node_wd.cur = r_first.child;
                stk_we      = 1'b1;
                stk_wa      = r_sp[AW-1:0];
                stk_wd      = r_v;
            end
            OP_WRD: node_ra = r_n;
            OP_WCHK: begin
                if (!node_rd.cok) begin
                    node_we     = 1'b1;
                    node_wa     = r_n;
                    node_wd     = node_rd;
                    node_wd.ext = r_timer;
                end else begin
                    node_ra = node_rd.cur;
                    sib_ra  = node_rd.cur;
                end
            end
            OP_WPOP: stk_ra = r_sp[AW-1:0] - AW'(1);
            OP_WSIB: begin
                node_we     = 1'b1;
                node_wa     = r_n;
                node_wd     = r_nrow;
                node_wd.cok = sib_rd.ok;
                node_wd.cur = sib_rd.nxt;
            end
            OP_ERDB: link_ra = b_addr;
            OP_ECHK: begin
                if (!link_rd.hp) begin
                    link_we    = 1'b1;
                    link_wa    = b_addr;
                    link_wd    = link_rd;
                    link_wd.hp = 1'b1;
                end
            end
            OP_ERDA: link_ra = a_addr;
            OP_EWR: begin
                sib_we        = 1'b1;
                sib_wa        = b_addr;
                sib_wd.ok     = link_rd.ok;
                sib_wd.nxt    = link_rd.child;
                link_we       = 1'b1;
                link_wa       = a_addr;
                link_wd.hp    = link_rd.hp;
                link_wd.ok    = 1'b1;
                link_wd.child = b_addr;
            end
            OP_Q0:  node_ra = a_addr;
            OP_Q1:  node_ra = b_addr;
            OP_QLA: anc_ra = r_x;
            OP_QLB: node_ra = anc_rd[r_lvl];
            OP_QF:  anc_ra = r_x;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc  <= CFG_W'(1);
            r_clr <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_nc <= i_cfg_wr_data;
            end
            if (i_ctl.op == OP_CLR) begin
                r_clr <= clr_last ? '0 : r_clr + AW'(1);
            end
        end
        case (i_ctl.op)
            OP_LATCH: begin
                r_cmd <= i_cmd;
                r_a   <= i_node_a;
                r_b   <= i_node_b;
            end
            OP_DECODE: begin
                r_ans  <= '0;
                r_stat <= bad && (r_cmd == CMD_ADD || r_cmd == CMD_QUERY);
            end
            OP_BINIT: begin
                r_timer <= '0;
                r_sp    <= '0;
                r_v     <= '0;
                r_p     <= '0;
            end
            OP_EN0: begin
                r_row[0] <= r_p;
                r_lvl    <= LVW'(1);
            end
            OP_EN1: r_first <= link_rd;
            OP_ENL: begin
                r_row[r_lvl] <= anc_rd[lvl_m1];
                r_lvl        <= r_lvl + LVW'(1);
            end
            OP_ENW: begin
                r_timer <= r_timer + TW'(1);
                r_sp    <= r_sp + (AW+1)'(1);
                r_n     <= r_v;
            end
            OP_WCHK: begin
                if (!node_rd.cok) begin
                    r_timer <= r_timer + TW'(1);
                    r_sp    <= sp_m1;
                end else begin
                    r_nrow <= node_rd;
                end
            end
            OP_WPOP2: r_n <= stk_rd;
            OP_WSIB: begin
                r_v <= r_nrow.cur;
                r_p <= r_n;
            end
            OP_Q1: begin
                r_ea <= node_rd.ent;
                r_xa <= node_rd.ext;
            end
            OP_Q2: begin
                r_eb <= node_rd.ent;
                r_xb <= node_rd.ext;
            end
            OP_Q3: begin
                if (o_sts.anc_ab) begin
                    r_ans <= a_addr;
                end else if (o_sts.anc_ba) begin
                    r_ans <= b_addr;
                end else begin
                    r_x   <= a_addr;
                    r_lvl <= LVW'(LOG_LEVELS - 1);
                end
            end
            OP_QLB: r_up <= anc_rd[r_lvl];
            OP_QLC: begin
                if (!up_anc) begin
                    r_x <= r_up;
                end
                r_lvl <= lvl_m1;
            end
            OP_QF2: r_ans <= anc_rd[0];
            OP_LOAD: begin
                r_out_ans  <= NODE_W'(r_ans);
                r_out_stat <= r_stat;
            end
            default: ;
        endcase
    end

    tlca_ram #(.WIDTH($bits(t_link)), .DEPTH(MAX_NODES)) u_link (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_wa), .i_wdata(link_wd),
        .i_raddr(link_ra), .o_rdata(link_rd)
    );

    tlca_ram #(.WIDTH($bits(t_sib)), .DEPTH(MAX_NODES)) u_sib (
        .i_clk(i_clk), .i_we(sib_we), .i_waddr(sib_wa), .i_wdata(sib_wd),
        .i_raddr(sib_ra), .o_rdata(sib_rd)
    );

    tlca_ram #(.WIDTH($bits(t_node)), .DEPTH(MAX_NODES)) u_node (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_wa), .i_wdata(node_wd),
        .i_raddr(node_ra), .o_rdata(node_rd)
    );

    tlca_ram #(.WIDTH($bits(t_row)), .DEPTH(MAX_NODES)) u_anc (
        .i_clk(i_clk), .i_we(anc_we), .i_waddr(anc_wa), .i_wdata(anc_wd),
        .i_raddr(anc_ra), .o_rdata(anc_rd)
    );

    tlca_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_wa), .i_wdata(stk_wd),
        .i_raddr(stk_ra), .o_rdata(stk_rd)
    );

endmodule

[hw/rtl/tree_lca_binary_lifting_core.sv]
// top level of the binary lifting lowest common ancestor engine
//
//  channel | direction | handshake                 | beat payload
//  --------+-----------+---------------------------+---------------------------
//  in      | to core   | i_in_valid / o_in_stall   | i_cmd, i_node_a, i_node_b
//  out     | from core | o_out_valid / i_out_stall | o_answer, o_status
//  cfg     | to core   | i_cfg_wr_en               | i_cfg_wr_data (node count)
//
//  one input beat in flight at a time; each beat gives exactly one output beat
//  add edge: child link check, parent link read, link write
//  rejected or unused command: decode, then straight to the result
//  query: one node-memory read and one ancestor-row read per lifting level
//  build: a clearing pass over all MAX_NODES table entries, then per reached
//  node the walk steps (entry, lifting chain, exit)
//  after reset a clearing pass over every entry runs with o_in_stall high
//  the output register holds a finished beat while the next input is accepted
module tree_lca_binary_lifting_core
    import tlca_pkg::*;
#(
    parameter int MAX_NODES  = DEF_MAX_NODES,
    parameter int LOG_LEVELS = DEF_LOG_LEVELS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input beats
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_cmd,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    // result beats
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [NODE_W-1:0] o_answer,
    output logic              o_status,
    // node count register
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data
);

    // controller to datapath command and status back
    t_dp_ctl ctl;
    t_dp_sts sts;

    // sequencing: reset clear, decode, edge insert, build walk, query lifting
    tlca_ctrl #(
        .LOG_LEVELS(LOG_LEVELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ctl       (ctl),
        .i_sts       (sts)
    );

    // tree memories, walk stack, time stamps and ancestor rows
    tlca_dp #(
        .MAX_NODES  (MAX_NODES),
        .LOG_LEVELS (LOG_LEVELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_cmd         (i_cmd),
        .i_node_a      (i_node_a),
        .i_node_b      (i_node_b),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_answer      (o_answer),
        .o_status      (o_status)
    );

endmodule

[hw/rtl/tlca_checker.sv]
// port level checks for the lca engine and their bind
module tlca_checker
    import tlca_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [NODE_W-1:0] o_answer,
    input logic              o_status
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_answer) && $stable(o_status))
        else $error("stalled result beat changed");

    // only one item in flight: the core stalls right after taking a beat
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    // an error status always carries a zero answer
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_answer == '0)
        else $error("error beat with nonzero answer");

    // a new result only appears while an item is being worked
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result beat without work");

endmodule

bind tree_lca_binary_lifting_core tlca_checker u_tlca_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_answer    (o_answer),
    .o_status    (o_status)
);
